// ===== hw/rtl/cgt_pkg.sv =====
// ----------------------------------------------------------------------------
// cgt_pkg: shared types and constants
// Input word, result word and result batch types, port offsets and
// bit positions of the character generator and timer write port.
// ----------------------------------------------------------------------------
package cgt_pkg;

    localparam int NumChannels = 3;
    localparam int NumPlanes   = 2;
    localparam int MaxResults  = 3;

    // port offsets
    localparam logic [1:0] PORT_DATA    = 2'd0;
    localparam logic [1:0] PORT_ADDR_LO = 2'd1;
    localparam logic [1:0] PORT_ADDR_HI = 2'd2;
    localparam logic [1:0] PORT_CTRL    = 2'd3;

    // unit select
    localparam logic FUNC_CHAR  = 1'b0;
    localparam logic FUNC_TIMER = 1'b1;

    // timer access modes
    localparam logic [1:0] MODE_LATCH = 2'd0;
    localparam logic [1:0] MODE_LSB   = 2'd1;
    localparam logic [1:0] MODE_MSB   = 2'd2;
    localparam logic [1:0] MODE_BOTH  = 2'd3;

    localparam logic [1:0] CH_NONE = 2'd3;

    // address bits
    localparam int AddrRamEnBit = 12;
    localparam int AddrFontBit  = 13;

    // gate bit of each channel in the address high byte
    localparam int GateBit0 = 3;
    localparam int GateBit1 = 6;
    localparam int GateBit2 = 7;

    localparam int WriteBankBit = 4;

    typedef struct packed {
        logic       func;
        logic [1:0] port;
        logic [7:0] data;
        logic [7:0] font_byte;
    } t_word;

    typedef struct packed {
        logic        ram_write;
        logic        ram_bank;
        logic [9:0]  ram_addr;
        logic [7:0]  ram_data;
        logic [1:0]  redraw_mask;
        logic        sound_event;
        logic [1:0]  sound_channel;
        logic        sound_on;
        logic [15:0] count_value;
        logic        count_bcd;
        logic        last;
    } t_result;

    typedef struct packed {
        t_result [MaxResults-1:0] res;
        logic [1:0]               cnt;
    } t_batch;

endpackage

// ===== hw/rtl/cgt_regs.sv =====
// ----------------------------------------------------------------------------
// cgt_regs: port register file and result decode
// Holds the character generator and timer state, applies one accepted
// write per cycle and decodes the up to three result words it causes.
// ----------------------------------------------------------------------------
module cgt_regs (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_acc,
    input  cgt_pkg::t_word  i_word,
    output cgt_pkg::t_batch o_batch
);
    import cgt_pkg::*;

    logic [7:0]  r_held_data, n_held_data;
    logic [15:0] r_pcg_addr,  n_pcg_addr;
    logic [NumChannels-1:0] r_gate, n_gate;
    logic [NumPlanes-1:0]   r_plane_bank, n_plane_bank;
    logic [NumPlanes-1:0]   r_plane_shown, n_plane_shown;
    logic        r_write_bank, n_write_bank;
    logic [1:0]  r_mode [NumChannels];
    logic [1:0]  n_mode [NumChannels];
    logic [15:0] r_count [NumChannels];
    logic [15:0] n_count [NumChannels];
    logic [NumChannels-1:0] r_high_next, n_high_next;
    logic [NumChannels-1:0] r_bcd, n_bcd;

    logic [NumChannels-1:0] w_gate_lvl;
    logic [1:0] w_ch;
    logic [1:0] w_nev;
    logic [1:0] w_redraw;
    logic       w_ramw;
    t_batch     w_batch;

    assign w_gate_lvl = {i_word.data[GateBit2], i_word.data[GateBit1], i_word.data[GateBit0]};
    assign w_ch       = i_word.data[7:6];

    always_comb begin
        n_held_data   = r_held_data;
        n_pcg_addr    = r_pcg_addr;
        n_gate        = r_gate;
        n_plane_bank  = r_plane_bank;
        n_plane_shown = r_plane_shown;
        n_write_bank  = r_write_bank;
        n_mode        = r_mode;
        n_count       = r_count;
        n_high_next   = r_high_next;
        n_bcd         = r_bcd;
        w_nev         = '0;
        w_redraw      = '0;
        w_ramw        = 1'b0;
        w_batch       = '0;

        if (i_word.func == FUNC_TIMER) begin
            if (i_word.port == PORT_CTRL) begin
                if (w_ch != CH_NONE) begin
                    n_mode[w_ch]      = i_word.data[5:4];
                    n_high_next[w_ch] = 1'b0;
                    n_bcd[w_ch]       = i_word.data[0];
                end
            end else begin
                case (r_mode[i_word.port])
                    MODE_LSB: n_count[i_word.port] = {8'h00, i_word.data};
                    MODE_MSB: n_count[i_word.port] = {i_word.data, 8'h00};
                    MODE_BOTH: begin
                        if (r_high_next[i_word.port])
                            n_count[i_word.port] = {i_word.data, r_count[i_word.port][7:0]};
                        else
                            n_count[i_word.port] = {r_count[i_word.port][15:8], i_word.data};
                        n_high_next[i_word.port] = ~r_high_next[i_word.port];
                    end
                    default: ;
                endcase
                w_batch.res[0].sound_event   = 1'b1;
                w_batch.res[0].sound_channel = i_word.port;
                w_batch.res[0].sound_on      = r_gate[i_word.port];
                w_batch.res[0].count_value   = n_count[i_word.port];
                w_batch.res[0].count_bcd     = r_bcd[i_word.port];
                w_batch.res[0].last          = 1'b1;
                w_batch.cnt                  = 2'd1;
            end
        end else if (i_word.port == PORT_CTRL) begin
            for (int p = 0; p < NumPlanes; p++) begin
                if ((i_word.data[2*p+1] && r_plane_bank[p] != i_word.data[2*p])
                        || i_word.data[2*p+1] != r_plane_shown[p])
                    w_redraw[p] = 1'b1;
                n_plane_shown[p] = i_word.data[2*p+1];
                n_plane_bank[p]  = i_word.data[2*p];
            end
            n_write_bank = i_word.data[WriteBankBit];
            if (w_redraw != '0) begin
                w_batch.res[0].redraw_mask = w_redraw;
                w_batch.res[0].last        = 1'b1;
                w_batch.cnt                = 2'd1;
            end
        end else begin
            case (i_word.port)
                PORT_DATA:    n_held_data = i_word.data;
                PORT_ADDR_LO: n_pcg_addr  = {r_pcg_addr[15:8], i_word.data};
                default: begin
                    n_pcg_addr = {i_word.data, r_pcg_addr[7:0]};
                    n_gate     = w_gate_lvl;
                end
            endcase

            // one sound word per gate that toggled, lowest channel first
            for (int c = 0; c < NumChannels; c++) begin
                if (n_gate[c] != r_gate[c]) begin
                    w_batch.res[w_nev].sound_event   = 1'b1;
                    w_batch.res[w_nev].sound_channel = 2'(c);
                    w_batch.res[w_nev].sound_on      = n_gate[c];
                    w_batch.res[w_nev].count_value   = r_count[c];
                    w_batch.res[w_nev].count_bcd     = r_bcd[c];
                    w_nev = w_nev + 2'd1;
                end
            end

            if (n_pcg_addr[AddrRamEnBit]) begin
                w_ramw = 1'b1;
                for (int p = 0; p < NumPlanes; p++)
                    if (r_plane_shown[p] && r_plane_bank[p] == r_write_bank)
                        w_redraw[p] = 1'b1;
                w_batch.res[0].ram_write   = 1'b1;
                w_batch.res[0].ram_bank    = r_write_bank;
                w_batch.res[0].ram_addr    = n_pcg_addr[9:0];
                w_batch.res[0].ram_data    = n_pcg_addr[AddrFontBit] ? i_word.font_byte
                                                                     : n_held_data;
                w_batch.res[0].redraw_mask = w_redraw;
            end

            w_batch.cnt = (w_ramw && w_nev == 2'd0) ? 2'd1 : w_nev;
            if (w_batch.cnt != 2'd0)
                w_batch.res[w_batch.cnt - 2'd1].last = 1'b1;
        end
    end

    assign o_batch = w_batch;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_data   <= '0;
            r_pcg_addr    <= '0;
            r_gate        <= '0;
            r_plane_bank  <= '0;
            r_plane_shown <= 2'b10;
            r_write_bank  <= 1'b0;
            r_high_next   <= '0;
            r_bcd         <= '0;
            for (int c = 0; c < NumChannels; c++) begin
                r_mode[c]  <= MODE_LATCH;
                r_count[c] <= 16'd1;
            end
        end else if (i_acc) begin
            r_held_data   <= n_held_data;
            r_pcg_addr    <= n_pcg_addr;
            r_gate        <= n_gate;
            r_plane_bank  <= n_plane_bank;
            r_plane_shown <= n_plane_shown;
            r_write_bank  <= n_write_bank;
            r_mode        <= n_mode;
            r_count       <= n_count;
            r_high_next   <= n_high_next;
            r_bcd         <= n_bcd;
        end
    end

endmodule

// ===== hw/rtl/char_gen_and_timer_port_regs.sv =====
// ----------------------------------------------------------------------------
// char_gen_and_timer_port_regs: character generator and tone timer write port
// Takes bus writes, updates the port registers and issues glyph RAM writes,
// redraw requests and sound updates as result words.
// ----------------------------------------------------------------------------
//  channel | handshake          | payload
//  --------+--------------------+-------------------------------------------
//  write   | i_valid / o_ready  | i_func, i_port, i_data, i_font_byte
//  result  | o_valid / i_ready  | o_ram_*, o_redraw_mask, o_sound_*, o_count_*,
//          |                    | o_last
//
//  A write is decoded in its accept cycle; its words sit in a three-entry
//  hold buffer and leave through the output register one per cycle while
//  the output is not stalled, so each word passes the hold buffer and then
//  the output register. Writes that give zero or one word are taken every
//  cycle while the output is not stalled; a write with more words holds the
//  next one until its last word moves to the output register. Output stalls
//  back up into the hold buffer and then o_ready. Reset is synchronous and
//  sets the port state and counts; buffered payload registers are not reset.
// ----------------------------------------------------------------------------
module char_gen_and_timer_port_regs (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_func,
    input  logic [1:0]  i_port,
    input  logic [7:0]  i_data,
    input  logic [7:0]  i_font_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_ram_write,
    output logic        o_ram_bank,
    output logic [9:0]  o_ram_addr,
    output logic [7:0]  o_ram_data,
    output logic [1:0]  o_redraw_mask,
    output logic        o_sound_event,
    output logic [1:0]  o_sound_channel,
    output logic        o_sound_on,
    output logic [15:0] o_count_value,
    output logic        o_count_bcd,
    output logic        o_last
);
    import cgt_pkg::*;

    t_word   w_word;
    t_batch  w_batch;
    logic    w_acc;
    logic    w_move;
    t_result r_pend [MaxResults];
    logic [1:0] r_pend_cnt;
    t_result r_out;
    logic    r_out_valid;

    assign w_word = '{func: i_func, port: i_port, data: i_data, font_byte: i_font_byte};

    assign w_move  = (r_pend_cnt != 2'd0) && (!r_out_valid || i_ready);
    assign o_ready = (r_pend_cnt == 2'd0) || (r_pend_cnt == 2'd1 && w_move);
    assign w_acc   = i_valid && o_ready;

    cgt_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_acc   (w_acc),
        .i_word  (w_word),
        .o_batch (w_batch)
    );

    // hold buffer: loaded with a whole batch, drained from entry 0
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_cnt <= '0;
        end else if (w_acc) begin
            r_pend_cnt <= w_batch.cnt;
        end else if (w_move) begin
            r_pend_cnt <= r_pend_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            for (int k = 0; k < MaxResults; k++)
                r_pend[k] <= w_batch.res[k];
        end else if (w_move) begin
            for (int k = 0; k < MaxResults - 1; k++)
                r_pend[k] <= r_pend[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_move) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_move)
            r_out <= r_pend[0];
    end

    assign o_valid         = r_out_valid;
    assign o_ram_write     = r_out.ram_write;
    assign o_ram_bank      = r_out.ram_bank;
    assign o_ram_addr      = r_out.ram_addr;
    assign o_ram_data      = r_out.ram_data;
    assign o_redraw_mask   = r_out.redraw_mask;
    assign o_sound_event   = r_out.sound_event;
    assign o_sound_channel = r_out.sound_channel;
    assign o_sound_on      = r_out.sound_on;
    assign o_count_value   = r_out.count_value;
    assign o_count_bcd     = r_out.count_bcd;
    assign o_last          = r_out.last;

endmodule

// ===== hw/rtl/cgt_checker.sv =====
// ----------------------------------------------------------------------------
// cgt_checker: port-level checks
// Watches the result channel of the write port and flags malformed words.
// ----------------------------------------------------------------------------
module cgt_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_ready,
    input logic        o_ram_write,
    input logic        o_ram_bank,
    input logic [9:0]  o_ram_addr,
    input logic [7:0]  o_ram_data,
    input logic [1:0]  o_redraw_mask,
    input logic        o_sound_event,
    input logic [1:0]  o_sound_channel,
    input logic        o_sound_on,
    input logic [15:0] o_count_value,
    input logic        o_count_bcd,
    input logic        o_last
);
    import cgt_pkg::*;

    // a word always carries something
    a_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_ram_write || o_sound_event || o_redraw_mask != 2'd0))
        else $error("empty result word");

    a_ram_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_ram_write) |->
            (!o_ram_bank && o_ram_addr == 10'd0 && o_ram_data == 8'd0))
        else $error("RAM fields set without a RAM write");

    a_sound_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_sound_event) |->
            (o_sound_channel == 2'd0 && !o_sound_on && o_count_value == 16'd0
             && !o_count_bcd))
        else $error("sound fields set without a sound event");

    a_channel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_sound_event) |-> (o_sound_channel != CH_NONE))
        else $error("sound event on nonexistent channel");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_last) && $stable(o_count_value)
                                   && $stable(o_ram_addr)))
        else $error("stalled result word changed");

endmodule

bind char_gen_and_timer_port_regs cgt_checker u_cgt_checker (.*);
